// File: hdl/pcp_pkg.sv
`default_nettype none
package pcp_pkg;

  // request and result field widths
  localparam int TargetW = 9;
  localparam int CountW  = 64;

  // memo table geometry
  localparam int MaxTargetPlusOne = 256;
  localparam int AddrW = $clog2(MaxTargetPlusOne);
  // pentagonal offsets can run a little past the largest index
  localparam int GenW  = AddrW + 2;
  // width for comparing a target magnitude against table indexes
  localparam int CmpW  = TargetW + AddrW;

  localparam logic [CountW-1:0] OutOfRangeCode = {CountW{1'b1}};

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture the request
    logic start_m;  // begin filling the next table entry
    logic rd_g1;    // read p(m - g1)
    logic rd_g2;    // read p(m - g2)
    logic acc;      // add or subtract the read value into the sum
    logic step_k;   // advance to the next pentagonal pair
    logic write_m;  // store the finished sum as p(m)
    logic rd_tgt;   // read p(target)
    logic put;      // load the result register
  } pcp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic tgt_neg;
    logic tgt_big;
    logic need_fill;
    logic term_done;
    logic g2_in;
    logic out_free;
  } pcp_stat_t;

endpackage
`default_nettype wire

// File: hdl/pcp_ifs.sv
`default_nettype none
// request channel
interface pcp_target_if import pcp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [TargetW-1:0] target;

  modport source (output valid, output target, input ready);
  modport sink   (input valid, input target, output ready);
endinterface

// result channel
interface pcp_count_if import pcp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] count;

  modport source (output valid, output count, input ready);
  modport sink   (input valid, input count, output ready);
endinterface
`default_nettype wire

// File: hdl/pcp_datapath.sv
`default_nettype none
module pcp_datapath import pcp_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire pcp_cmd_t                  cmd,
  output pcp_stat_t                      stat,
  input  wire logic signed [TargetW-1:0] in_target,
  output logic [CountW-1:0]              out_count,
  output logic                           out_valid,
  input  wire logic                      out_ready
);

  logic [CountW-1:0]         mem [MaxTargetPlusOne];
  logic signed [TargetW-1:0] tgt;
  logic [AddrW-1:0]          filled;
  logic [AddrW-1:0]          m;
  logic [GenW-1:0]           g1;
  logic [GenW-1:0]           g2;
  logic [GenW-1:0]           inc;
  logic                      add_sign;
  logic [CountW-1:0]         sum;
  logic [CountW-1:0]         rd_data;
  logic                      rd_zero;
  logic [CountW-1:0]         count;

  logic [CmpW-1:0]           tgt_mag;
  logic [AddrW-1:0]          tgt_addr;
  logic [AddrW-1:0]          rd_addr;
  logic                      rd_en;
  logic [CountW-1:0]         rd_value;
  logic [GenW-1:0]           m_ext;

  assign tgt_mag  = CmpW'(tgt[TargetW-2:0]);
  assign tgt_addr = tgt_mag[AddrW-1:0];
  assign m_ext    = GenW'(m);

  // status back to the controller
  assign stat.tgt_neg   = tgt[TargetW-1];
  assign stat.tgt_big   = tgt_mag >= CmpW'(MaxTargetPlusOne);
  assign stat.need_fill = CmpW'(filled) < tgt_mag;
  assign stat.term_done = g1 > m_ext;
  assign stat.g2_in     = g2 <= m_ext;
  assign stat.out_free  = !out_valid || out_ready;

  // table read address select
  assign rd_en = cmd.rd_g1 || cmd.rd_g2 || cmd.rd_tgt;
  always_comb begin
    priority if (cmd.rd_tgt) begin
      rd_addr = tgt_addr;
    end else if (cmd.rd_g2) begin
      rd_addr = AddrW'(m_ext - g2);
    end else begin
      rd_addr = AddrW'(m_ext - g1);
    end
  end

  // p(0) is fixed at one and never stored
  assign rd_value = rd_zero ? CountW'(1) : rd_data;

  // memo table
  always_ff @(posedge clk) begin
    if (cmd.write_m) begin
      mem[m] <= sum;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_zero <= (rd_addr == '0);
    end
  end

  // request capture and recurrence registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt <= in_target;
    end
    if (cmd.start_m) begin
      m        <= AddrW'(filled + 1'b1);
      sum      <= '0;
      g1       <= GenW'(1);
      g2       <= GenW'(2);
      inc      <= GenW'(4);
      add_sign <= 1'b1;
    end
    if (cmd.acc) begin
      sum <= add_sign ? (sum + rd_value) : (sum - rd_value);
    end
    if (cmd.step_k) begin
      g1       <= g1 + inc;
      g2       <= g2 + inc + GenW'(1);
      inc      <= inc + GenW'(3);
      add_sign <= ~add_sign;
    end
  end

  // fill level of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (cmd.write_m) begin
      filled <= m;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      priority if (tgt[TargetW-1]) begin
        count <= '0;
      end else if (stat.tgt_big) begin
        count <= OutOfRangeCode;
      end else begin
        count <= rd_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_count = count;

`ifndef ASSERT_OFF
  // entries are written strictly in order
  a_fill_order: assert property (@(posedge clk) disable iff (rst)
    cmd.write_m |-> (m == AddrW'(filled + 1'b1)))
    else $error("table entry written out of order");

  // a term is only read while its offset lies inside the table
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_g1 |-> !stat.term_done)
    else $error("pentagonal read beyond current index");

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> stat.out_free)
    else $error("result register overwritten");

  // a loaded result is offered in the next cycle
  a_put_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.put |=> out_valid)
    else $error("result not offered after load");
`endif

endmodule
`default_nettype wire

// File: hdl/pcp_ctrl.sv
`default_nettype none
module pcp_ctrl import pcp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire pcp_stat_t stat,
  output pcp_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_NEXT  = 3'd2;
  localparam logic [2:0] S_TERM  = 3'd3;
  localparam logic [2:0] S_A1    = 3'd4;
  localparam logic [2:0] S_A2    = 3'd5;
  localparam logic [2:0] S_PUT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.tgt_neg || stat.tgt_big) begin
          state_next = S_PUT;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (stat.need_fill) begin
          cmd.start_m = 1'b1;
          state_next  = S_TERM;
        end else begin
          cmd.rd_tgt = 1'b1;
          state_next = S_PUT;
        end
      end
      S_TERM: begin
        if (stat.term_done) begin
          cmd.write_m = 1'b1;
          state_next  = S_NEXT;
        end else begin
          cmd.rd_g1  = 1'b1;
          state_next = S_A1;
        end
      end
      S_A1: begin
        cmd.acc    = 1'b1;
        cmd.rd_g2  = 1'b1;
        state_next = S_A2;
      end
      S_A2: begin
        cmd.acc    = stat.g2_in;
        cmd.step_k = 1'b1;
        state_next = S_TERM;
      end
      S_PUT: begin
        if (stat.out_free) begin
          cmd.put    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/partition_count_pentagonal.sv
`default_nettype none
// Partition counter: each request transfer carries a signed target n and yields one
// result transfer with p(n), the number of partitions of n (0 for negative n, 1 for
// n = 0, all ones for n at or beyond the table size). Values come from Euler's
// pentagonal recurrence over a 64-bit memo table that keeps its entries across
// requests, so only entries above the highest one computed so far cost time. The
// single table read port sets the pace: each new entry p(m) takes two table reads
// per pentagonal pair k with k(3k-1)/2 <= m, then one write. One request is handled
// at a time; a finished result waits in an output register.
module partition_count_pentagonal import pcp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  pcp_target_if.sink req,
  pcp_count_if.source rsp
);

  pcp_cmd_t  cmd;
  pcp_stat_t stat;

  pcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_target (req.target),
    .out_count (rsp.count),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready)
  );

endmodule
`default_nettype wire

// File: bench/pcp_count_checker.sv
`timescale 1ns / 1ps
// watches the request and result channels, predicts p(target) with its own memo
// table and compares every result transfer with the oldest prediction
module pcp_count_checker import pcp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic                      req_ready,
  input  logic signed [TargetW-1:0] req_target,
  input  logic                      rsp_valid,
  input  logic                      rsp_ready,
  input  logic [CountW-1:0]         rsp_count,
  output int                        fail_count,
  output int                        outstanding,
  output int                        checked
);

  logic [CountW-1:0] partition_memo [MaxTargetPlusOne];
  int                memo_top;
  logic [CountW-1:0] expected_counts [$];
  int                fails;
  int                seen;

  // grow the memo table up to n with the pentagonal recurrence, then look it up
  function automatic logic [CountW-1:0] predict_partitions(
      input logic signed [TargetW-1:0] n);
    int                m;
    int                k;
    int                g1;
    int                g2;
    logic [CountW-1:0] sum;
    logic [CountW-1:0] term;
    if (n < 0) return '0;
    if (int'(n) >= MaxTargetPlusOne) return OutOfRangeCode;
    while (memo_top < int'(n)) begin
      memo_top++;
      m   = memo_top;
      sum = '0;
      k   = 1;
      g1  = 1;
      while (g1 <= m) begin
        // second generalized pentagonal number of the pair is g1 + k
        g2   = g1 + k;
        term = partition_memo[m - g1];
        if (g2 <= m) term = term + partition_memo[m - g2];
        if (k % 2 == 1) sum = sum + term;
        else sum = sum - term;
        k++;
        g1 = (3 * k * k - k) / 2;
      end
      partition_memo[m] = sum;
    end
    return partition_memo[int'(n)];
  endfunction

  initial begin
    fails = 0;
    seen  = 0;
    fail_count  = 0;
    outstanding = 0;
    checked     = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      // only p(0) is known after reset
      partition_memo[0] = 1;
      memo_top          = 0;
      expected_counts.delete();
    end else begin
      // request transfer: predict its count
      if (req_valid && req_ready)
        expected_counts.push_back(predict_partitions(req_target));

      // result transfer: compare with the oldest prediction
      if (rsp_valid && rsp_ready) begin
        seen++;
        if (expected_counts.size() == 0) begin
          $error("count: unexpected result transfer, actual %0d", rsp_count);
          fails++;
        end else begin
          if (rsp_count !== expected_counts[0]) begin
            $error("count mismatch: expected %0d, actual %0d",
                   expected_counts[0], rsp_count);
            fails++;
          end
          void'(expected_counts.pop_front());
        end
      end
    end
    fail_count  <= fails;
    outstanding <= expected_counts.size();
    checked     <= seen;
  end

endmodule

// File: bench/tb_partition_count_pentagonal.sv
`timescale 1ns / 1ps
// drives requests into the partition counter with varying idle patterns on both
// channels; a checker beside the block predicts and compares the counts
module tb_partition_count_pentagonal;
  import pcp_pkg::*;

  localparam int NumRandom  = 105;
  localparam int HoldCycles = 80;
  localparam int NumDirected = 25;
  // growing targets fill the table in steps, then sign and range extremes
  localparam int DirectedTargets [NumDirected] = '{
    0, 1, 2, 3, 4, 5, 7, 12, 26, 57, 100, 100, 99, -1, -2,
    -128, -255, -256, 127, 128, 200, 254, 255, 255, 6
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  pcp_target_if req_if ();
  pcp_count_if  rsp_if ();

  int fail_count;
  int outstanding;
  int checked;
  int send_idle_pct;
  int rcv_idle_pct;
  logic hold_req;
  int hold_left;
  bit hold_done;
  int sent;
  int negatives;

  partition_count_pentagonal dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  pcp_count_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_if.valid),
    .req_ready   (req_if.ready),
    .req_target  (req_if.target),
    .rsp_valid   (rsp_if.valid),
    .rsp_ready   (rsp_if.ready),
    .rsp_count   (rsp_if.count),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one request transfer, with random idle cycles in front of it
  task automatic send_target(input logic signed [TargetW-1:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.target <= t;
    sent++;
    if (t < 0) negatives++;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    hold_left = 0;
    hold_done = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic signed [TargetW-1:0] t;
    sent      = 0;
    negatives = 0;
    send_idle_pct = 18;
    rcv_idle_pct  <= 49;
    hold_req      <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.target <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed targets
    for (int i = 0; i < NumDirected; i++)
      send_target(TargetW'(DirectedTargets[i]));

    // random targets over three idle phases
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 3) begin
        send_idle_pct = 49;
        rcv_idle_pct  <= 18;
      end else if (i == 2 * NumRandom / 3) begin
        send_idle_pct = 0;
        rcv_idle_pct  <= 0;
        hold_req      <= 1'b1;
      end
      if ($urandom_range(0, 99) < 60)
        t = TargetW'($urandom_range(0, (1 << TargetW) - 1));
      else
        t = TargetW'(int'($urandom_range(0, 40)) - 20);
      send_target(t);
    end
    req_if.valid <= 1'b0;

    // drain and let the block settle
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d requests (%0d negative) and %0d checked counts,",
             sent, negatives, checked);
    $display("table filled from reset to its top, with stalls on both channels");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run time limit
  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
